// ----- rtl/hbk_pkg.sv -----
package hbk_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned BUCKET_W = 31;
  localparam int unsigned KEY_W    = 64;

  localparam logic [HASH_W-1:0] MURMUR_SEED  = 32'd42;
  localparam logic [HASH_W-1:0] MIX_C1       = 32'hcc9e_2d51;
  localparam logic [HASH_W-1:0] MIX_C2       = 32'h1b87_3593;
  localparam logic [HASH_W-1:0] MIX_ADD      = 32'he654_6b64;
  localparam logic [HASH_W-1:0] FMIX_C1      = 32'h85eb_ca6b;
  localparam logic [HASH_W-1:0] FMIX_C2      = 32'hc2b2_ae35;
  localparam logic [HASH_W-1:0] ROW_LEN      = 32'd16;

  // One restoring division step per bit of the hash magnitude.
  localparam int unsigned MOD_STEPS = HASH_W;

  typedef logic [HASH_W-1:0]   hash_t;
  typedef logic [BUCKET_W-1:0] bucket_t;

  function automatic hash_t rotl15(input hash_t x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic hash_t rotl13(input hash_t x);
    return {x[18:0], x[31:19]};
  endfunction

  // h * 5 + MIX_ADD, written as a shift and two adds.
  function automatic hash_t mul5_add(input hash_t x);
    return (x << 2) + x + MIX_ADD;
  endfunction

  function automatic hash_t mix_block(input hash_t h, input hash_t k);
    hash_t kk;
    hash_t hh;
    kk = k * MIX_C1;
    kk = rotl15(kk);
    kk = kk * MIX_C2;
    hh = h ^ kk;
    hh = rotl13(hh);
    return mul5_add(hh);
  endfunction

  // The eight leading zero bytes always give the same state: fold at elaboration.
  localparam hash_t H_INIT = mix_block(mix_block(MURMUR_SEED, '0), '0);

endpackage

// ----- rtl/hash_bucket_id_from_key.sv -----
// Bucket number from an integer key.
// The slave stream carries one key per word: tdata holds the 64-bit key and
// tuser flags a 64-bit key; when tuser is low only the low 32 bits count.
// The key is hashed as a 16-byte row (eight zero bytes, then the key) with
// MurmurHash3 x86_32, seed 42, and the magnitude of the signed hash is
// reduced modulo the bucket count. The master stream returns the bucket
// number in the low 31 bits of tdata.
// The bucket count is written on the configuration channel, which is always
// ready; write it only while no word is in flight. Reset sets it to one.
// The pipeline has seven hash stages followed by 32 restoring division
// stages, one quotient bit each. A new word is taken every cycle unless the output stalls.
// All stages advance together; when the receiver stalls with a word on the
// output, the whole pipeline holds and the slave side deasserts tready, so
// no word is dropped or repeated.
// Reset clears every valid bit, so the output carries no word after reset.
module hash_bucket_id_from_key (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] key_value
  input  logic        s_axis_tuser_i,   // [0] key_is_wide
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] bucket_id, [31] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);
  import hbk_pkg::*;

  logic    en;
  logic    hash_valid;
  hash_t   hash_mag;
  hash_t   key_hi;
  bucket_t bucket_count_q;
  bucket_t bucket_id;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;
  assign key_hi          = s_axis_tuser_i ? s_axis_tdata_i[KEY_W-1:HASH_W] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= bucket_t'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  hbk_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .lo_i    (s_axis_tdata_i[HASH_W-1:0]),
    .hi_i    (key_hi),
    .valid_o (hash_valid),
    .mag_o   (hash_mag)
  );

  hbk_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (hash_valid),
    .mag_i     (hash_mag),
    .divisor_i (bucket_count_q),
    .valid_o   (m_axis_tvalid_o),
    .rem_o     (bucket_id)
  );

  assign m_axis_tdata_o = {1'b0, bucket_id};

endmodule

// ----- rtl/hbk_hash.sv -----
module hbk_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  hbk_pkg::hash_t lo_i,
  input  hbk_pkg::hash_t hi_i,
  output logic          valid_o,
  output hbk_pkg::hash_t mag_o
);
  import hbk_pkg::*;

  logic [6:0] v_q;
  hash_t klo1_q, khi1_q;
  hash_t klo2_q, khi2_q;
  hash_t h3_q, khi3_q;
  hash_t h4_q;
  hash_t h5_q;
  hash_t h6_q;
  hash_t mag7_q;

  hash_t h4_mix, h4_d, h6_x, h7_x;

  always_comb begin
    h4_mix = mul5_add(rotl13(h3_q ^ khi3_q)) ^ ROW_LEN;
    h4_d   = h4_mix ^ (h4_mix >> 16);
    h6_x   = h5_q ^ (h5_q >> 13);
    h7_x   = h6_q ^ (h6_q >> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      klo1_q <= lo_i * MIX_C1;
      khi1_q <= hi_i * MIX_C1;
      klo2_q <= rotl15(klo1_q) * MIX_C2;
      khi2_q <= rotl15(khi1_q) * MIX_C2;
      h3_q   <= mul5_add(rotl13(H_INIT ^ klo2_q));
      khi3_q <= khi2_q;
      h4_q   <= h4_d;
      h5_q   <= h4_q * FMIX_C1;
      h6_q   <= h6_x * FMIX_C2;
      mag7_q <= h7_x[HASH_W-1] ? (hash_t'(0) - h7_x) : h7_x;
    end
  end

  assign valid_o = v_q[6];
  assign mag_o   = mag7_q;

endmodule

// ----- rtl/hbk_mod.sv -----
module hbk_mod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  hbk_pkg::hash_t   mag_i,
  input  hbk_pkg::bucket_t divisor_i,
  output logic             valid_o,
  output hbk_pkg::bucket_t rem_o
);
  import hbk_pkg::*;

  logic [MOD_STEPS-1:0] v_q;
  bucket_t rem_q [MOD_STEPS];
  hash_t   dvd_q [MOD_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[MOD_STEPS-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < MOD_STEPS; i++) begin : g_step
    bucket_t rem_in;
    hash_t   dvd_in;
    hash_t   shifted;
    hash_t   diff;
    logic    ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = mag_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvd_in = dvd_q[i-1];
    end

    always_comb begin
      shifted = {rem_in, dvd_in[HASH_W-1]};
      diff    = shifted - {1'b0, divisor_i};
      ge      = shifted >= {1'b0, divisor_i};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[BUCKET_W-1:0] : shifted[BUCKET_W-1:0];
        dvd_q[i] <= {dvd_in[HASH_W-2:0], 1'b0};
      end
    end
  end

  assign valid_o = v_q[MOD_STEPS-1];
  // A zero bucket count lies outside the legal range and yields bucket zero.
  assign rem_o   = (divisor_i == '0) ? '0 : rem_q[MOD_STEPS-1];

endmodule

// ----- rtl/hbk_checker.sv -----
module hbk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed under stall");

  // The input side is ready exactly when the output can move.
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output state");

  // The bucket number fits in 31 bits.
  a_top_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("bucket number overflows 31 bits");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("output word present right after reset");

endmodule

bind hash_bucket_id_from_key hbk_checker u_hbk_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hbk_pkg::hash_t;
  import hbk_pkg::bucket_t;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  localparam hash_t SEED      = 32'd42;
  localparam hash_t ROW_BYTES = 32'd16;
  localparam hash_t K_MUL1    = 32'hcc9e_2d51;
  localparam hash_t K_MUL2    = 32'h1b87_3593;
  localparam hash_t H_ADD     = 32'he654_6b64;
  localparam hash_t F_MUL1    = 32'h85eb_ca6b;
  localparam hash_t F_MUL2    = 32'hc2b2_ae35;
  localparam hash_t MIN_HASH  = 32'h8000_0000;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  wire         s_tready;
  logic [63:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  wire         m_tvalid;
  logic        m_tready  = 1'b0;
  wire  [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  bucket_t     cfg_data  = '0;

  bucket_t     due_buckets[$];
  bucket_t     bucket_count = 31'd1;
  bucket_t     due_now;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned keys_sent = 0;
  int unsigned wide_keys = 0;
  int unsigned min_hash_keys = 0;
  int unsigned settings_used = 0;

  hash_bucket_id_from_key DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic hash_t rotl(hash_t x, int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic hash_t rotr(hash_t x, int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

  function automatic hash_t scramble(hash_t k);
    return rotl(k * K_MUL1, 15) * K_MUL2;
  endfunction

  function automatic hash_t absorb(hash_t h, hash_t k);
    return rotl(h ^ scramble(k), 13) * 32'd5 + H_ADD;
  endfunction

  function automatic hash_t avalanche(hash_t h);
    hash_t x;
    x = h ^ (h >> 16);
    x = x * F_MUL1;
    x = x ^ (x >> 13);
    x = x * F_MUL2;
    return x ^ (x >> 16);
  endfunction

  function automatic hash_t row_hash(logic [63:0] key, logic wide);
    hash_t h;
    h = absorb(SEED, '0);
    h = absorb(h, '0);
    h = absorb(h, key[31:0]);
    h = absorb(h, wide ? key[63:32] : 32'd0);
    return avalanche(h ^ ROW_BYTES);
  endfunction

  function automatic bucket_t bucket_for_key(logic [63:0] key, logic wide, bucket_t count);
    hash_t h;
    hash_t mag;
    h = row_hash(key, wide);
    mag = h[31] ? -h : h;
    if (count == '0) begin
      return '0;
    end
    return bucket_t'(mag % {1'b0, count});
  endfunction

  function automatic hash_t odd_inverse(hash_t a);
    hash_t x;
    x = a;
    repeat (5) x = x * (32'd2 - a * x);
    return x;
  endfunction

  // Runs the hash backwards to find the low key word that yields a chosen hash.
  function automatic hash_t key_for_hash(hash_t target, hash_t high);
    hash_t h;
    hash_t want;
    h = target ^ (target >> 16);
    h = h * odd_inverse(F_MUL2);
    h = h ^ (h >> 13) ^ (h >> 26);
    h = h * odd_inverse(F_MUL1);
    h = h ^ (h >> 16);
    h = h ^ ROW_BYTES;
    h = rotr((h - H_ADD) * odd_inverse(32'd5), 13) ^ scramble(high);
    want = rotr((h - H_ADD) * odd_inverse(32'd5), 13) ^ absorb(absorb(SEED, '0), '0);
    return rotr(want * odd_inverse(K_MUL2), 15) * odd_inverse(K_MUL1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("tb: mismatch on %s: expected %h, got %h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  task automatic send_key(input logic [63:0] key, input logic wide);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= wide;
    do @(posedge clk_i); while (!s_tready);
    due_buckets.push_back(bucket_for_key(key, wide, bucket_count));
    keys_sent++;
    if (wide) wide_keys++;
    if (row_hash(key, wide) == MIN_HASH) min_hash_keys++;
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_buckets.size() != 0);
  endtask

  task automatic set_bucket_count(input bucket_t value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    bucket_count = value;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_key();
    logic        wide;
    logic [63:0] key;
    hash_t       target;
    int unsigned pick;
    wide = 1'($urandom_range(0, 1));
    key  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 5))
        0:       target = MIN_HASH;
        1:       target = 32'h7fff_ffff;
        2:       target = 32'hffff_ffff;
        3:       target = '0;
        4:       target = {1'b0, bucket_count} * $urandom_range(1, 1000);
        default: target = {1'b0, bucket_count} * $urandom_range(1, 1000) - 32'd1;
      endcase
      if ($urandom_range(0, 1)) target = -target;
      key[31:0] = key_for_hash(target, wide ? key[63:32] : 32'd0);
    end else if (pick < 35) begin
      key = 64'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) key = -key;
    end else if (pick < 45) begin
      key[63:32] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    send_key(key, wide);
  endtask

  task automatic test_reset_value();
    send_key(64'h0, 1'b1);
    send_key(64'hffff_ffff_ffff_ffff, 1'b1);
    send_key(64'h1234_5678, 1'b0);
  endtask

  task automatic test_field_extremes();
    set_bucket_count(31'h7fff_ffff);
    send_key(64'h0, 1'b0);
    send_key(64'h0, 1'b1);
    send_key(64'hffff_ffff_ffff_ffff, 1'b0);
    send_key(64'hffff_ffff_ffff_ffff, 1'b1);
    send_key(64'h8000_0000_0000_0000, 1'b1);
    send_key(64'h7fff_ffff_ffff_ffff, 1'b1);
    send_key(64'h8000_0000_0000_0000, 1'b0);
    send_key(64'hdead_beef_0000_0001, 1'b0);
    send_key(64'h1, 1'b0);
    send_key(64'h0000_0000_ffff_ffff, 1'b1);
    send_key({32'ha5a5_a5a5, key_for_hash(MIN_HASH, '0)}, 1'b0);
    send_key({32'h0000_0001, key_for_hash(MIN_HASH, 32'h1)}, 1'b1);
    send_key({32'h0, key_for_hash(32'h7fff_ffff, '0)}, 1'b0);
    send_key({32'hffff_ffff, key_for_hash(32'hffff_ffff, 32'hffff_ffff)}, 1'b1);
    send_key({32'h5a5a_5a5a, key_for_hash('0, '0)}, 1'b0);
    set_bucket_count(31'd2);
    send_key({32'h0, key_for_hash(MIN_HASH, '0)}, 1'b0);
  endtask

  task automatic test_zero_count();
    set_bucket_count('0);
    send_key({32'h0, key_for_hash(MIN_HASH, '0)}, 1'b0);
    send_key(64'hffff_ffff_ffff_ffff, 1'b1);
    send_key(64'h0123_4567_89ab_cdef, 1'b0);
  endtask

  task automatic test_random_phases();
    bucket_t counts[8];
    counts[0] = 31'd1;
    counts[1] = 31'd2;
    counts[2] = 31'd3;
    counts[3] = 31'h7fff_ffff;
    counts[4] = 31'h4000_0000;
    counts[5] = bucket_t'($urandom_range(4, 64));
    counts[6] = bucket_t'($urandom_range(65, 100000));
    counts[7] = bucket_t'($urandom) | 31'h4000_0001;
    foreach (counts[i]) begin
      set_bucket_count(counts[i]);
      repeat (150) send_random_key();
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
      default:  m_tready <= (cycle_count % 7) > 2;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (due_buckets.size() == 0) begin
        report_mismatch("unexpected word", '0, m_tdata);
      end else begin
        due_now = due_buckets.pop_front();
        if (m_tdata[30:0] !== due_now) report_mismatch("bucket_id", {1'b0, due_now}, m_tdata);
        if (m_tdata[31] !== 1'b0) report_mismatch("tdata bit 31", '0, m_tdata);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: timeout with %0d words outstanding", due_buckets.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_value();
    test_field_extremes();
    test_zero_count();
    test_random_phases();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb: %0d keys sent, %0d of them wide, across %0d bucket count writes",
             keys_sent, wide_keys, settings_used);
    $display("tb: %0d keys hashed to the most negative value, %0d mismatches",
             min_hash_keys, errors);
    if (errors == 0 && due_buckets.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hbk_pkg.sv
rtl/hbk_hash.sv
rtl/hbk_mod.sv
rtl/hash_bucket_id_from_key.sv
rtl/hbk_checker.sv
tb/tb.sv
